// ----- sv/plic_pkg.sv -----
// Shared types and codes for the piecewise linear interpolator.
package plic_pkg;

  localparam int MaxPointsDef = 64;
  localparam int IdxW = 6;

  localparam logic [1:0] ADDR_POINT_COUNT = 2'd0;

  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_LOW = 2'd1;
  localparam logic [1:0] ST_HIGH = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  // One breakpoint write, broadcast to every cell.
  typedef struct packed {
    logic en;
    logic [IdxW-1:0] idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } wr_t;

  // Query word travelling down the row of cells.
  typedef struct packed {
    logic valid;
    logic found;
    logic signed [31:0] q;
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] xf;
    logic signed [31:0] yf;
    logic signed [31:0] xl;
    logic signed [31:0] yl;
  } carry_t;

endpackage

// ----- sv/plic_cell.sv -----
// One breakpoint cell: stores (x, y) and tests its segment against a passing query.
module plic_cell #(
  parameter int IDX = 0,
  parameter int CW = 7
) (
  input  logic clk,
  input  logic rst,
  input  plic_pkg::wr_t wr,
  input  logic [CW-1:0] n_last,
  input  logic signed [31:0] nb_x,
  input  logic signed [31:0] nb_y,
  output logic signed [31:0] own_x,
  output logic signed [31:0] own_y,
  input  plic_pkg::carry_t cin,
  output plic_pkg::carry_t cout
);
  import plic_pkg::*;

  carry_t c_next;
  logic hit;

  always_ff @(posedge clk) begin
    if ((IDX < 64) && wr.en && (wr.idx == IdxW'(IDX))) begin
      own_x <= wr.x;
      own_y <= wr.y;
    end
  end

  always_comb begin
    hit = ((own_x <= cin.q) && (cin.q <= nb_x)) || ((nb_x <= cin.q) && (cin.q <= own_x));
    c_next = cin;
    if (IDX == 0) begin
      c_next.xf = own_x;
      c_next.yf = own_y;
    end
    if (CW'(IDX) == n_last) begin
      c_next.xl = own_x;
      c_next.yl = own_y;
    end
    if ((CW'(IDX) < n_last) && hit) begin
      c_next.found = 1'b1;
      c_next.x0 = own_x;
      c_next.y0 = own_y;
      c_next.x1 = nb_x;
      c_next.y1 = nb_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout.valid <= 1'b0;
    end else begin
      cout.valid <= cin.valid;
    end
    cout.found <= c_next.found;
    cout.q <= c_next.q;
    cout.x0 <= c_next.x0;
    cout.y0 <= c_next.y0;
    cout.x1 <= c_next.x1;
    cout.y1 <= c_next.y1;
    cout.xf <= c_next.xf;
    cout.yf <= c_next.yf;
    cout.xl <= c_next.xl;
    cout.yl <= c_next.yl;
  end

endmodule

// ----- sv/plic_muldiv.sv -----
// Iterative unit: shift-add multiply of two magnitudes, then restoring divide.
module plic_muldiv (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [32:0] a,
  input  logic [32:0] b,
  input  logic [32:0] d,
  output logic done,
  output logic [32:0] quo
);
  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL = 2'd1;
  localparam logic [1:0] P_DIV = 2'd2;

  logic [1:0] phase;
  logic [6:0] cnt;
  logic [65:0] mcand;
  logic [32:0] mplier;
  logic [65:0] prod;
  logic [32:0] dvs;
  logic [33:0] rem;
  logic [33:0] r2;
  logic ge;

  always_comb begin
    r2 = {rem[32:0], prod[65]};
    ge = r2 >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (start) begin
            phase <= P_MUL;
            cnt <= 7'd0;
            mcand <= {33'd0, a};
            mplier <= b;
            prod <= '0;
            dvs <= d;
          end
        end
        P_MUL: begin
          if (mplier[0]) begin
            prod <= prod + mcand;
          end
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
          if (cnt == 7'd32) begin
            phase <= P_DIV;
            cnt <= 7'd0;
            rem <= '0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        P_DIV: begin
          // The product shifts out at the top while quotient bits shift in.
          rem <= ge ? (r2 - {1'b0, dvs}) : r2;
          prod <= prod << 1;
          quo <= {quo[31:0], ge};
          if (cnt == 7'd65) begin
            phase <= P_IDLE;
            done <= 1'b1;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/piecewise_linear_interpolator.sv -----
// Piecewise linear interpolator: breakpoint table in a row of cells and a shared divider.
//
// Input words arrive on in_valid/in_ready. A word with req_type 0 stores one
// breakpoint and yields no output word. A word with req_type 1 is a query: it
// walks the row of MAX_POINTS cells, one cell per cycle, each cell testing its
// own segment. Interpolated answers then pass a shift-add multiplier and a
// restoring divider; clamped answers, unmatched queries and segments with
// equal ends skip both. One query is in flight at a time.
// Results leave on out_valid/out_ready from an output register; the next input
// word is taken while a result still waits there. If the receiver stalls, a
// finished query is held until the output register frees.
// The APB port holds point_count at address 0. Reset sets point_count to 2 and
// clears all control state; the breakpoints are undefined until written.
module piecewise_linear_interpolator #(
  parameter int MAX_POINTS = plic_pkg::MaxPointsDef
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_ready,
  input  logic req_type,
  input  logic [5:0] point_index,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] query_x,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] result_y,
  output logic [1:0] status
);
  import plic_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;
  localparam logic [1:0] S_FIN = 2'd3;

  logic [1:0] state;
  logic [6:0] point_count;
  logic [CW-1:0] n_last;
  wr_t wr;
  carry_t chain [MAX_POINTS+1];
  logic signed [31:0] cx [MAX_POINTS];
  logic signed [31:0] cy [MAX_POINTS];
  carry_t co;
  logic signed [32:0] dx, dy, dq;
  logic [32:0] mdx, mdy, mdq;
  logic neg_c;
  logic signed [31:0] y0;
  logic neg;
  logic signed [31:0] res;
  logic [1:0] st;
  logic md_start, md_done;
  logic [32:0] md_quo;

  assign pready = 1'b1;
  assign prdata = {25'd0, point_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 7'd2;
    end else if (psel && penable && pwrite && (paddr == ADDR_POINT_COUNT)) begin
      point_count <= pwdata[6:0];
    end
  end

  always_comb begin
    if (point_count < 7'd2) begin
      n_last = CW'(1);
    end else if (32'(point_count) > MAX_POINTS) begin
      n_last = CW'(MAX_POINTS - 1);
    end else begin
      n_last = CW'(32'(point_count) - 1);
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    wr.en = in_valid && in_ready && !req_type;
    wr.idx = point_index;
    wr.x = point_x;
    wr.y = point_y;
    chain[0] = '0;
    chain[0].valid = in_valid && in_ready && req_type;
    chain[0].q = query_x;
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    plic_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk(clk),
      .rst(rst),
      .wr(wr),
      .n_last(n_last),
      .nb_x(cx[(i + 1 < MAX_POINTS) ? i + 1 : i]),
      .nb_y(cy[(i + 1 < MAX_POINTS) ? i + 1 : i]),
      .own_x(cx[i]),
      .own_y(cy[i]),
      .cin(chain[i]),
      .cout(chain[i+1])
    );
  end

  assign co = chain[MAX_POINTS];

  always_comb begin
    dx = 33'(co.x1) - 33'(co.x0);
    dy = 33'(co.y1) - 33'(co.y0);
    dq = 33'(co.q) - 33'(co.x0);
    mdx = dx[32] ? 33'(-dx) : 33'(dx);
    mdy = dy[32] ? 33'(-dy) : 33'(dy);
    mdq = dq[32] ? 33'(-dq) : 33'(dq);
    neg_c = ((dy[32] != dq[32]) != dx[32]) && (dy != '0) && (dq != '0);
  end

  // The query word sits at the end of the row for one cycle only, so the
  // divider takes its operands in that same cycle.
  always_comb begin
    md_start = (state == S_SCAN) && co.valid && !(co.xl < co.q) && !(co.q < co.xf) &&
               co.found && (dx != '0);
  end

  plic_muldiv u_md (
    .clk(clk),
    .rst(rst),
    .start(md_start),
    .a(mdy),
    .b(mdq),
    .d(mdx),
    .done(md_done),
    .quo(md_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FIN) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && req_type) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (co.valid) begin
            y0 <= co.y0;
            neg <= neg_c;
            if (co.xl < co.q) begin
              res <= co.yl;
              st <= ST_HIGH;
              state <= S_FIN;
            end else if (co.q < co.xf) begin
              res <= co.yf;
              st <= ST_LOW;
              state <= S_FIN;
            end else if (!co.found) begin
              res <= '0;
              st <= ST_NONE;
              state <= S_FIN;
            end else if (dx == '0) begin
              res <= co.y0;
              st <= ST_INTERP;
              state <= S_FIN;
            end else begin
              st <= ST_INTERP;
              state <= S_CALC;
            end
          end
        end
        S_CALC: begin
          if (md_done) begin
            res <= neg ? (y0 - md_quo[31:0]) : (y0 + md_quo[31:0]);
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            result_y <= res;
            status <= st;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
